// File: hdl/fsnf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fsnf_pkg;

  localparam int unsigned FSNF_POINTER_BITS = 32;
  localparam int unsigned FSNF_NUM_DIG      = 20;
  localparam logic [31:0] FSNF_BUF_RESET    = 32'd8192;

  typedef struct packed {
    logic [7:0]  fmt_char;
    logic [63:0] arg_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_char;
    logic        run_end;
    logic        string_end;
    logic [31:0] char_count;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic shift;
    logic data;
  } bcd_ctrl_t;

  typedef enum logic [1:0] {
    PH_TEXT,
    PH_PCT,
    PH_ZERO,
    PH_CONV
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_COUNT,
    ST_EMIT
  } state_e;

  typedef enum logic {
    MODE_HEX,
    MODE_DEC
  } mode_e;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = CH_0 + {4'h0, nib};
    end else if (upper) begin
      r = 8'h41 + {4'h0, nib - 4'd10};
    end else begin
      r = 8'h61 + {4'h0, nib - 4'd10};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/fsnf_bcd_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module fsnf_bcd_cell (
  input  wire logic       clk_i,
  input  wire logic       clear_i,
  input  wire logic       shift_i,
  input  wire logic       carry_i,
  output logic            carry_o,
  output logic [3:0]      digit_o
);

  logic [3:0] digit_q, digit_d, adj;

  always_comb begin
    adj     = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
    carry_o = adj[3];
    digit_d = digit_q;
    if (clear_i) begin
      digit_d = 4'd0;
    end else if (shift_i) begin
      digit_d = {adj[2:0], carry_i};
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign digit_o = digit_q;

endmodule
`default_nettype wire

// File: hdl/fsnf_bcd_row.sv
`timescale 1ns / 1ps
`default_nettype none
module fsnf_bcd_row #(
  parameter int unsigned NumDig = fsnf_pkg::FSNF_NUM_DIG
) (
  input  wire logic                  clk_i,
  input  wire fsnf_pkg::bcd_ctrl_t   ctrl_i,
  output logic [NumDig-1:0][3:0]     digits_o
);

  logic [NumDig:0] carry;

  assign carry[0] = ctrl_i.data;

  for (genvar g = 0; g < NumDig; g++) begin : g_cell
    fsnf_bcd_cell u_cell (
      .clk_i   (clk_i),
      .clear_i (ctrl_i.clear),
      .shift_i (ctrl_i.shift),
      .carry_i (carry[g]),
      .carry_o (carry[g+1]),
      .digit_o (digits_o[g])
    );
  end

endmodule
`default_nettype wire

// File: hdl/format_string_number_formatter_core.sv
// Timing: a text byte gives its item, registered, in the cycle after it is taken; a hex
// conversion moves to ST_EMIT, which registers each digit. Decimal conversions shift the
// 32- or 64-bit magnitude through a row of 20 BCD cells in ST_DABBLE and size the field
// in ST_COUNT before ST_EMIT. Throughput: one text byte a cycle while the output is not
// stalled; a conversion holds the input until its last item.
// Reset: asynchronous, active low; buffer size returns to 8192 and the run state clears.
`timescale 1ns / 1ps
`default_nettype none
module format_string_number_formatter_core #(
  parameter int unsigned POINTER_BITS = fsnf_pkg::FSNF_POINTER_BITS
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire fsnf_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output fsnf_pkg::out_item_t      out_item_o,
  input  wire logic                cfg_we_i,
  input  wire logic [31:0]         cfg_data_i
);

  localparam int unsigned NumDig = fsnf_pkg::FSNF_NUM_DIG;
  localparam int unsigned PDigRaw = POINTER_BITS / 4;
  localparam int unsigned PDig = (PDigRaw < 8) ? 8 : ((PDigRaw > 16) ? 16 : PDigRaw);

  fsnf_pkg::state_e    state_q, state_d;
  fsnf_pkg::phase_e    phase_q, phase_d;
  fsnf_pkg::mode_e     mode_q, mode_d;
  logic [3:0]          pw_q, pw_d;
  logic                pz_q, pz_d;
  logic [31:0]         written_q, written_d;
  logic                full_q, full_d;
  logic [31:0]         buf_q;
  logic                out_valid_q, out_valid_d;
  fsnf_pkg::out_item_t out_q, out_d;
  logic [63:0]         arg_q, arg_d;
  logic [63:0]         mag_q, mag_d;
  logic [6:0]          iter_q, iter_d;
  logic [4:0]          idx_q, idx_d;
  logic [4:0]          nd_q, nd_d;
  logic                upper_q, upper_d;
  logic                minus_q, minus_d;

  fsnf_pkg::bcd_ctrl_t     bcd_ctrl;
  logic [NumDig-1:0][3:0]  digits;

  fsnf_bcd_row #(.NumDig(NumDig)) u_row (
    .clk_i    (clk_i),
    .ctrl_i   (bcd_ctrl),
    .digits_o (digits)
  );

  logic [31:0] limit;
  logic        slot_free, at_limit, last_fit;
  logic        accept;
  logic [7:0]  c;
  logic [63:0] a;
  logic [31:0] neg32;
  logic [4:0]  nd_calc, len_calc;
  logic [7:0]  ch;
  logic        seq_last;

  assign limit      = buf_q - 32'd1;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign at_limit   = written_q >= limit;
  assign last_fit   = (written_q + 32'd1) == limit;
  assign in_ready_o = (state_q == fsnf_pkg::ST_IDLE) && slot_free;
  assign accept     = in_valid_i && in_ready_o;
  assign c          = in_item_i.fmt_char;
  assign a          = in_item_i.arg_value;
  assign neg32      = 32'd0 - a[31:0];

  always_comb begin
    nd_calc = 5'd1;
    for (int i = 1; i < NumDig; i++) begin
      if (digits[i] != 4'd0) begin
        nd_calc = 5'(i + 1);
      end
    end
    len_calc = (nd_calc > {1'b0, pw_q}) ? nd_calc : {1'b0, pw_q};
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    mode_d      = mode_q;
    pw_d        = pw_q;
    pz_d        = pz_q;
    written_d   = written_q;
    full_d      = full_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    arg_d       = arg_q;
    mag_d       = mag_q;
    iter_d      = iter_q;
    idx_d       = idx_q;
    nd_d        = nd_q;
    upper_d     = upper_q;
    minus_d     = minus_q;
    bcd_ctrl    = '0;
    ch          = fsnf_pkg::CH_NUL;
    seq_last    = 1'b1;
    unique case (state_q)
      fsnf_pkg::ST_IDLE: begin
        if (accept) begin
          logic do_conv, single;
          do_conv = 1'b0;
          single  = 1'b0;
          if (c == fsnf_pkg::CH_NUL) begin
            out_valid_d = 1'b1;
            out_d       = '{out_char: fsnf_pkg::CH_NUL, run_end: 1'b1,
                            string_end: 1'b1, char_count: written_q};
            phase_d     = fsnf_pkg::PH_TEXT;
            pw_d        = 4'd0;
            pz_d        = 1'b0;
            written_d   = 32'd0;
            full_d      = 1'b0;
          end else if (!full_q) begin
            unique case (phase_q)
              fsnf_pkg::PH_TEXT: begin
                if (c == fsnf_pkg::CH_PCT) begin
                  phase_d = fsnf_pkg::PH_PCT;
                end else begin
                  single = 1'b1;
                  ch     = c;
                end
              end
              fsnf_pkg::PH_PCT: begin
                if (c == fsnf_pkg::CH_0 || c == fsnf_pkg::CH_DOT) begin
                  pw_d    = 4'd0;
                  phase_d = fsnf_pkg::PH_ZERO;
                end else if (c >= fsnf_pkg::CH_1 && c <= fsnf_pkg::CH_9) begin
                  pw_d    = c[3:0];
                  pz_d    = 1'b0;
                  phase_d = fsnf_pkg::PH_CONV;
                end else begin
                  do_conv = 1'b1;
                end
              end
              fsnf_pkg::PH_ZERO: begin
                if (c >= fsnf_pkg::CH_0 && c <= fsnf_pkg::CH_9) begin
                  pw_d    = c[3:0];
                  pz_d    = 1'b1;
                  phase_d = fsnf_pkg::PH_CONV;
                end else begin
                  do_conv = 1'b1;
                end
              end
              default: do_conv = 1'b1;
            endcase
            if (do_conv) begin
              phase_d = fsnf_pkg::PH_TEXT;
              arg_d   = a;
              upper_d = (c[5] == 1'b0);
              minus_d = 1'b0;
              unique case (c)
                fsnf_pkg::CH_PCT: begin single = 1'b1; ch = fsnf_pkg::CH_PCT; end
                8'h63, 8'h43: begin single = 1'b1; ch = a[7:0]; end
                8'h64, 8'h69, 8'h44, 8'h49: begin
                  mode_d   = fsnf_pkg::MODE_DEC;
                  minus_d  = a[31];
                  mag_d    = {(a[31] ? neg32 : a[31:0]), 32'd0};
                  iter_d   = 7'd32;
                  bcd_ctrl.clear = 1'b1;
                  state_d  = fsnf_pkg::ST_DABBLE;
                end
                8'h75, 8'h55: begin
                  mode_d   = fsnf_pkg::MODE_DEC;
                  mag_d    = {a[31:0], 32'd0};
                  iter_d   = 7'd32;
                  bcd_ctrl.clear = 1'b1;
                  state_d  = fsnf_pkg::ST_DABBLE;
                end
                8'h6c: begin
                  mode_d   = fsnf_pkg::MODE_DEC;
                  mag_d    = a;
                  iter_d   = 7'd64;
                  bcd_ctrl.clear = 1'b1;
                  state_d  = fsnf_pkg::ST_DABBLE;
                end
                8'h4c: begin
                  mode_d   = fsnf_pkg::MODE_DEC;
                  minus_d  = a[63];
                  mag_d    = a[63] ? 64'd0 - a : a;
                  iter_d   = 7'd64;
                  bcd_ctrl.clear = 1'b1;
                  state_d  = fsnf_pkg::ST_DABBLE;
                end
                8'h62, 8'h42: begin
                  mode_d = fsnf_pkg::MODE_HEX; idx_d = 5'd1; state_d = fsnf_pkg::ST_EMIT;
                end
                8'h77, 8'h57: begin
                  mode_d = fsnf_pkg::MODE_HEX; idx_d = 5'd3; state_d = fsnf_pkg::ST_EMIT;
                end
                8'h78, 8'h58: begin
                  mode_d = fsnf_pkg::MODE_HEX; idx_d = 5'd7; state_d = fsnf_pkg::ST_EMIT;
                end
                8'h71, 8'h51: begin
                  mode_d = fsnf_pkg::MODE_HEX; idx_d = 5'd15; state_d = fsnf_pkg::ST_EMIT;
                end
                8'h70, 8'h50: begin
                  mode_d  = fsnf_pkg::MODE_HEX;
                  idx_d   = 5'(PDig - 1);
                  state_d = fsnf_pkg::ST_EMIT;
                end
                default: ;
              endcase
            end
            if (single) begin
              if (at_limit) begin
                full_d = 1'b1;
              end else begin
                out_valid_d = 1'b1;
                out_d       = '{out_char: ch, run_end: 1'b1, string_end: 1'b0,
                                char_count: written_q + 32'd1};
                written_d   = written_q + 32'd1;
              end
            end
          end
        end
      end
      fsnf_pkg::ST_DABBLE: begin
        bcd_ctrl.shift = 1'b1;
        bcd_ctrl.data  = mag_q[63];
        mag_d          = {mag_q[62:0], 1'b0};
        iter_d         = iter_q - 7'd1;
        if (iter_q == 7'd1) begin
          state_d = fsnf_pkg::ST_COUNT;
        end
      end
      fsnf_pkg::ST_COUNT: begin
        nd_d    = nd_calc;
        idx_d   = len_calc - 5'd1;
        state_d = fsnf_pkg::ST_EMIT;
      end
      default: begin
        if (mode_q == fsnf_pkg::MODE_HEX) begin
          ch       = fsnf_pkg::hex_char(arg_q[{idx_q[3:0], 2'b00} +: 4], upper_q);
          seq_last = (idx_q == 5'd0);
        end else if (minus_q) begin
          ch       = fsnf_pkg::CH_MINUS;
          seq_last = 1'b0;
        end else begin
          ch       = (idx_q < nd_q) ? fsnf_pkg::CH_0 + {4'h0, digits[idx_q]}
                   : (pz_q ? fsnf_pkg::CH_0 : fsnf_pkg::CH_SPACE);
          seq_last = (idx_q == 5'd0);
        end
        if (slot_free) begin
          if (at_limit) begin
            full_d  = 1'b1;
            state_d = fsnf_pkg::ST_IDLE;
          end else begin
            out_valid_d = 1'b1;
            out_d       = '{out_char: ch, run_end: seq_last || last_fit, string_end: 1'b0,
                            char_count: written_q + 32'd1};
            written_d   = written_q + 32'd1;
            if (mode_q == fsnf_pkg::MODE_DEC && minus_q) begin
              minus_d = 1'b0;
            end else if (seq_last) begin
              state_d = fsnf_pkg::ST_IDLE;
            end else begin
              idx_d = idx_q - 5'd1;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fsnf_pkg::ST_IDLE;
      phase_q     <= fsnf_pkg::PH_TEXT;
      pw_q        <= 4'd0;
      pz_q        <= 1'b0;
      written_q   <= 32'd0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
      buf_q       <= fsnf_pkg::FSNF_BUF_RESET;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      pw_q        <= pw_d;
      pz_q        <= pz_d;
      written_q   <= written_d;
      full_q      <= full_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        buf_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    arg_q   <= arg_d;
    mag_q   <= mag_d;
    iter_q  <= iter_d;
    idx_q   <= idx_d;
    nd_q    <= nd_d;
    mode_q  <= mode_d;
    upper_q <= upper_d;
    minus_q <= minus_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == fsnf_pkg::ST_IDLE))
    else $error("input ready outside idle");

  a_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && c == fsnf_pkg::CH_NUL) |=>
      (out_valid_q && out_q.string_end && written_q == 32'd0 && !full_q))
    else $error("terminator not produced or run not cleared");

  a_term_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.string_end) |-> out_q.run_end)
    else $error("terminator without run end");

  a_emit_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fsnf_pkg::ST_EMIT) |-> (idx_q < 5'(NumDig)))
    else $error("emit index out of range");

endmodule
`default_nettype wire
